### rtl/core/tgr_pkg.sv
package tgr_pkg;

    localparam int COORD_BITS = 12;
    localparam int TIME_BITS  = 32;
    localparam int STEPS_BITS = 8;
    localparam int PROD_BITS  = COORD_BITS + STEPS_BITS;

    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH   = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_SWIPE_STEPS    = 3'd2;
    localparam logic [2:0] REG_DTAP_WINDOW    = 3'd3;
    localparam logic [2:0] REG_TAP_MOVE_LIMIT = 3'd4;
    localparam logic [2:0] REG_LONG_PRESS     = 3'd5;
    localparam logic [2:0] REG_POLL_INTERVAL  = 3'd6;
    localparam logic [2:0] REG_SWIPE_START    = 3'd7;

    localparam logic [11:0] RST_SCREEN_WIDTH   = 12'd320;
    localparam logic [11:0] RST_SCREEN_HEIGHT  = 12'd240;
    localparam logic [7:0]  RST_SWIPE_STEPS    = 8'd40;
    localparam logic [15:0] RST_DTAP_WINDOW    = 16'd300;
    localparam logic [11:0] RST_TAP_MOVE_LIMIT = 12'd24;
    localparam logic [15:0] RST_LONG_PRESS     = 16'd1000;
    localparam logic [7:0]  RST_POLL_INTERVAL  = 8'd20;
    localparam logic [11:0] RST_SWIPE_START    = 12'd20;

    localparam logic [TIME_BITS-1:0] TAP_MIN_MS = TIME_BITS'(50);

    // gesture direction codes
    localparam logic [2:0] DIR_STAY    = 3'd0;
    localparam logic [2:0] DIR_REQUEST = 3'd1;
    localparam logic [2:0] DIR_LEFT    = 3'd2;
    localparam logic [2:0] DIR_RIGHT   = 3'd3;
    localparam logic [2:0] DIR_UP      = 3'd4;
    localparam logic [2:0] DIR_DOWN    = 3'd5;

    localparam logic [1:0] MODE_PLAYER   = 2'd0;
    localparam logic [1:0] MODE_VOLUME   = 2'd1;
    localparam logic [1:0] MODE_STATIONS = 2'd2;

    localparam logic [1:0] REQ_NONE     = 2'd0;
    localparam logic [1:0] REQ_VOLUME   = 2'd1;
    localparam logic [1:0] REQ_STATIONS = 2'd2;
    localparam logic [1:0] REQ_PLAYER   = 2'd3;

    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_POS  = 2'd1;
    localparam logic [1:0] STEP_NEG  = 2'd2;

    typedef struct packed {
        logic                  touched;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [TIME_BITS-1:0]  now_ms;
        logic [1:0]            screen_mode;
    } in_word_t;

    typedef struct packed {
        logic       click;
        logic       double_tap;
        logic [1:0] mode_request;
        logic [1:0] step;
    } out_word_t;

    typedef struct packed {
        logic [11:0] screen_width;
        logic [11:0] screen_height;
        logic [7:0]  swipe_steps;
        logic [15:0] double_tap_window_ms;
        logic [11:0] tap_move_limit;
        logic [15:0] long_press_ms;
        logic [7:0]  poll_interval_ms;
        logic [11:0] swipe_start_distance;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic calc;
        logic commit;
    } cmd_t;

    function automatic logic [COORD_BITS-1:0] absdiff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] b
    );
        logic [COORD_BITS-1:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

endpackage

### rtl/core/tgr_cfg.sv
module tgr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tgr_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [tgr_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [tgr_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output tgr_pkg::cfg_t                       cfg
);

    tgr_pkg::cfg_t cfg_reg;
    tgr_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                tgr_pkg::REG_SCREEN_WIDTH:   cfg_next.screen_width = pwdata[11:0];
                tgr_pkg::REG_SCREEN_HEIGHT:  cfg_next.screen_height = pwdata[11:0];
                tgr_pkg::REG_SWIPE_STEPS:    cfg_next.swipe_steps = pwdata[7:0];
                tgr_pkg::REG_DTAP_WINDOW:    cfg_next.double_tap_window_ms = pwdata[15:0];
                tgr_pkg::REG_TAP_MOVE_LIMIT: cfg_next.tap_move_limit = pwdata[11:0];
                tgr_pkg::REG_LONG_PRESS:     cfg_next.long_press_ms = pwdata[15:0];
                tgr_pkg::REG_POLL_INTERVAL:  cfg_next.poll_interval_ms = pwdata[7:0];
                tgr_pkg::REG_SWIPE_START:    cfg_next.swipe_start_distance = pwdata[11:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            tgr_pkg::REG_SCREEN_WIDTH:   prdata = 32'(cfg_reg.screen_width);
            tgr_pkg::REG_SCREEN_HEIGHT:  prdata = 32'(cfg_reg.screen_height);
            tgr_pkg::REG_SWIPE_STEPS:    prdata = 32'(cfg_reg.swipe_steps);
            tgr_pkg::REG_DTAP_WINDOW:    prdata = 32'(cfg_reg.double_tap_window_ms);
            tgr_pkg::REG_TAP_MOVE_LIMIT: prdata = 32'(cfg_reg.tap_move_limit);
            tgr_pkg::REG_LONG_PRESS:     prdata = 32'(cfg_reg.long_press_ms);
            tgr_pkg::REG_POLL_INTERVAL:  prdata = 32'(cfg_reg.poll_interval_ms);
            tgr_pkg::REG_SWIPE_START:    prdata = 32'(cfg_reg.swipe_start_distance);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width         <= tgr_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height        <= tgr_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.swipe_steps          <= tgr_pkg::RST_SWIPE_STEPS;
            cfg_reg.double_tap_window_ms <= tgr_pkg::RST_DTAP_WINDOW;
            cfg_reg.tap_move_limit       <= tgr_pkg::RST_TAP_MOVE_LIMIT;
            cfg_reg.long_press_ms        <= tgr_pkg::RST_LONG_PRESS;
            cfg_reg.poll_interval_ms     <= tgr_pkg::RST_POLL_INTERVAL;
            cfg_reg.swipe_start_distance <= tgr_pkg::RST_SWIPE_START;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/tgr_ctrl.sv
module tgr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output tgr_pkg::cmd_t cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // output register can take a word when empty or being drained
    assign slot_free  = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;

    assign cmd.load   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.calc   = (state_reg == ST_CALC);
    assign cmd.commit = (state_reg == ST_COMMIT) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (cmd.commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_CALC))
        else $error("accepted word did not enter calc");

    a_calc_to_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC) |=> (state_reg == ST_COMMIT))
        else $error("calc not followed by commit");

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || !out_stall))
        else $error("commit would overwrite a waiting result");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

endmodule

### rtl/core/tgr_dp.sv
module tgr_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  tgr_pkg::cmd_t      cmd,
    input  tgr_pkg::cfg_t      cfg,
    input  tgr_pkg::in_word_t  in_data,
    output tgr_pkg::out_word_t out_data
);

    localparam int CB = tgr_pkg::COORD_BITS;
    localparam int TB = tgr_pkg::TIME_BITS;
    localparam int PB = tgr_pkg::PROD_BITS;

    tgr_pkg::in_word_t  in_reg;
    tgr_pkg::out_word_t out_reg;
    tgr_pkg::out_word_t out_next;

    // gesture state
    logic          was_touched_reg, was_touched_next;
    logic [2:0]    dir_reg, dir_next;
    logic [CB-1:0] origin_x_reg, origin_x_next;
    logic [CB-1:0] origin_y_reg, origin_y_next;
    logic [CB-1:0] vol_anchor_reg, vol_anchor_next;
    logic [CB-1:0] sta_anchor_reg, sta_anchor_next;
    logic [CB-1:0] last_x_reg, last_x_next;
    logic [CB-1:0] last_y_reg, last_y_next;
    logic [TB-1:0] press_start_reg, press_start_next;
    logic          pending_reg, pending_next;
    logic [TB-1:0] pending_ms_reg, pending_ms_next;
    logic [CB-1:0] pending_x_reg, pending_x_next;
    logic [CB-1:0] pending_y_reg, pending_y_next;
    logic [TB-1:0] last_poll_reg, last_poll_next;

    // calc stage results
    logic          click_reg;
    logic          poll_ok_reg;
    logic [2:0]    dir_calc_reg;
    logic [PB-1:0] prod_x_reg;
    logic [PB-1:0] prod_y_reg;
    logic          still_reg;
    logic          near_pend_reg;
    logic          short_reg;
    logic          tap_time_reg;
    logic          in_window_reg;

    logic [TB-1:0] t_pend;
    logic [TB-1:0] t_poll;
    logic [TB-1:0] t_held;
    logic [CB-1:0] ax;
    logic [CB-1:0] ay;
    logic [CB-1:0] dist_vx;
    logic [CB-1:0] dist_sy;
    logic [2:0]    dir_c;
    logic [CB-1:0] size_x;
    logic [CB-1:0] size_y;
    logic [PB-1:0] lim_x;
    logic [PB-1:0] lim_y;
    logic          due_x;
    logic          due_y;

    assign out_data = out_reg;

    // calc: time differences, direction, distance products
    always_comb
    begin
        t_pend  = in_reg.now_ms - pending_ms_reg;
        t_poll  = in_reg.now_ms - last_poll_reg;
        t_held  = in_reg.now_ms - press_start_reg;
        ax      = tgr_pkg::absdiff(in_reg.pos_x, origin_x_reg);
        ay      = tgr_pkg::absdiff(in_reg.pos_y, origin_y_reg);
        dist_vx = tgr_pkg::absdiff(vol_anchor_reg, in_reg.pos_x);
        dist_sy = tgr_pkg::absdiff(sta_anchor_reg, in_reg.pos_y);
        if (ax > CB'(cfg.swipe_start_distance) || ay > CB'(cfg.swipe_start_distance))
        begin
            if (ax > ay)
                dir_c = (in_reg.pos_x > origin_x_reg) ? tgr_pkg::DIR_RIGHT
                                                      : tgr_pkg::DIR_LEFT;
            else
                dir_c = (in_reg.pos_y > origin_y_reg) ? tgr_pkg::DIR_DOWN
                                                      : tgr_pkg::DIR_UP;
        end
        else
        begin
            dir_c = tgr_pkg::DIR_REQUEST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_data;
        if (cmd.calc)
        begin
            click_reg     <= !was_touched_reg && pending_reg &&
                             (t_pend > TB'(cfg.double_tap_window_ms));
            poll_ok_reg   <= t_poll > TB'(cfg.poll_interval_ms);
            dir_calc_reg  <= dir_c;
            prod_x_reg    <= PB'(dist_vx) * PB'(cfg.swipe_steps);
            prod_y_reg    <= PB'(dist_sy) * PB'(cfg.swipe_steps);
            still_reg     <= (tgr_pkg::absdiff(last_x_reg, origin_x_reg) <
                              CB'(cfg.tap_move_limit)) &&
                             (tgr_pkg::absdiff(last_y_reg, origin_y_reg) <
                              CB'(cfg.tap_move_limit));
            near_pend_reg <= (tgr_pkg::absdiff(last_x_reg, pending_x_reg) <
                              CB'(cfg.tap_move_limit)) &&
                             (tgr_pkg::absdiff(last_y_reg, pending_y_reg) <
                              CB'(cfg.tap_move_limit));
            short_reg     <= t_held < TB'(cfg.long_press_ms);
            tap_time_reg  <= t_held > tgr_pkg::TAP_MIN_MS;
            in_window_reg <= t_pend <= TB'(cfg.double_tap_window_ms);
        end
        if (cmd.commit)
            out_reg <= out_next;
    end

    // zero size counts as one; step when dist*steps >= 2*size
    always_comb
    begin
        size_x = (cfg.screen_width == '0) ? CB'(1) : CB'(cfg.screen_width);
        size_y = (cfg.screen_height == '0) ? CB'(1) : CB'(cfg.screen_height);
        lim_x  = PB'({size_x, 1'b0});
        lim_y  = PB'({size_y, 1'b0});
        due_x  = prod_x_reg >= lim_x;
        due_y  = prod_y_reg >= lim_y;
    end

    // commit: state update and result word
    always_comb
    begin
        was_touched_next = was_touched_reg;
        dir_next         = dir_reg;
        origin_x_next    = origin_x_reg;
        origin_y_next    = origin_y_reg;
        vol_anchor_next  = vol_anchor_reg;
        sta_anchor_next  = sta_anchor_reg;
        last_x_next      = last_x_reg;
        last_y_next      = last_y_reg;
        press_start_next = press_start_reg;
        pending_next     = pending_reg;
        pending_ms_next  = pending_ms_reg;
        pending_x_next   = pending_x_reg;
        pending_y_next   = pending_y_reg;
        last_poll_next   = last_poll_reg;

        out_next.click        = click_reg;
        out_next.double_tap   = 1'b0;
        out_next.mode_request = tgr_pkg::REQ_NONE;
        out_next.step         = tgr_pkg::STEP_NONE;

        if (click_reg)
            pending_next = 1'b0;

        if (poll_ok_reg)
        begin
            last_poll_next = in_reg.now_ms;
            if (in_reg.touched)
            begin
                last_x_next = in_reg.pos_x;
                last_y_next = in_reg.pos_y;
                if (!was_touched_reg)
                begin
                    origin_x_next    = in_reg.pos_x;
                    origin_y_next    = in_reg.pos_y;
                    vol_anchor_next  = in_reg.pos_x;
                    sta_anchor_next  = in_reg.pos_y;
                    dir_next         = tgr_pkg::DIR_REQUEST;
                    press_start_next = in_reg.now_ms;
                end
                else
                begin
                    dir_next = dir_calc_reg;
                    if (dir_calc_reg inside {tgr_pkg::DIR_LEFT, tgr_pkg::DIR_RIGHT})
                    begin
                        press_start_next = in_reg.now_ms;
                        if (in_reg.screen_mode inside {tgr_pkg::MODE_PLAYER,
                                                       tgr_pkg::MODE_VOLUME})
                        begin
                            out_next.mode_request = tgr_pkg::REQ_VOLUME;
                            if (due_x)
                            begin
                                out_next.step   = (in_reg.pos_x < vol_anchor_reg) ?
                                                  tgr_pkg::STEP_POS : tgr_pkg::STEP_NEG;
                                vol_anchor_next = in_reg.pos_x;
                            end
                        end
                    end
                    else if (dir_calc_reg inside {tgr_pkg::DIR_UP, tgr_pkg::DIR_DOWN})
                    begin
                        press_start_next = in_reg.now_ms;
                        if (in_reg.screen_mode inside {tgr_pkg::MODE_PLAYER,
                                                       tgr_pkg::MODE_STATIONS})
                        begin
                            out_next.mode_request = tgr_pkg::REQ_STATIONS;
                            if (due_y)
                            begin
                                out_next.step   = (in_reg.pos_y > sta_anchor_reg) ?
                                                  tgr_pkg::STEP_POS : tgr_pkg::STEP_NEG;
                                sta_anchor_next = in_reg.pos_y;
                            end
                        end
                    end
                end
            end
            else if (was_touched_reg)
            begin
                if (dir_reg == tgr_pkg::DIR_REQUEST)
                begin
                    if (short_reg)
                    begin
                        if (tap_time_reg && still_reg)
                        begin
                            if (pending_reg && in_window_reg && near_pend_reg)
                            begin
                                pending_next        = 1'b0;
                                out_next.double_tap = 1'b1;
                            end
                            else
                            begin
                                pending_next    = 1'b1;
                                pending_ms_next = in_reg.now_ms;
                                pending_x_next  = last_x_reg;
                                pending_y_next  = last_y_reg;
                            end
                        end
                        else
                        begin
                            pending_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pending_next          = 1'b0;
                        out_next.mode_request = (in_reg.screen_mode == tgr_pkg::MODE_PLAYER) ?
                                                tgr_pkg::REQ_STATIONS : tgr_pkg::REQ_PLAYER;
                    end
                end
                dir_next = tgr_pkg::DIR_STAY;
            end
            was_touched_next = in_reg.touched;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_touched_reg <= 1'b1;
            dir_reg         <= tgr_pkg::DIR_STAY;
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            vol_anchor_reg  <= '0;
            sta_anchor_reg  <= '0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            press_start_reg <= '0;
            pending_reg     <= 1'b0;
            pending_ms_reg  <= '0;
            pending_x_reg   <= '0;
            pending_y_reg   <= '0;
            last_poll_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            was_touched_reg <= was_touched_next;
            dir_reg         <= dir_next;
            origin_x_reg    <= origin_x_next;
            origin_y_reg    <= origin_y_next;
            vol_anchor_reg  <= vol_anchor_next;
            sta_anchor_reg  <= sta_anchor_next;
            last_x_reg      <= last_x_next;
            last_y_reg      <= last_y_next;
            press_start_reg <= press_start_next;
            pending_reg     <= pending_next;
            pending_ms_reg  <= pending_ms_next;
            pending_x_reg   <= pending_x_next;
            pending_y_reg   <= pending_y_next;
            last_poll_reg   <= last_poll_next;
        end
    end

endmodule

### rtl/core/touch_gesture_recognizer.sv
// an accepted word is loaded into the input register, then passes the calc and
// commit states; a new word is taken only back in idle, and commit waits
// while a finished result sits in the output register and out_stall is high
// the calc stage holds the two 12x8 distance multipliers; commit updates state
// reset: control and gesture state take their reset values at once, config
// registers take their defaults; no clearing pass, ready right after reset
module touch_gesture_recognizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tgr_pkg::in_word_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output tgr_pkg::out_word_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tgr_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [tgr_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tgr_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);

    tgr_pkg::cfg_t cfg;
    tgr_pkg::cmd_t cmd;

    tgr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tgr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    tgr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

### tb/touch_gesture_recognizer_tb.sv
`timescale 1ns / 100ps

module touch_gesture_recognizer_tb;

    localparam logic [1:0] MODE_OTHER = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int COORD_MAX = (1 << tgr_pkg::COORD_BITS) - 1;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_pattern_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    tgr_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    tgr_pkg::out_word_t out_data;

    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [tgr_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [tgr_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [tgr_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                              pready;

    touch_gesture_recognizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predicted gesture state and register copy
    tgr_pkg::cfg_t gesture_cfg;
    logic          was_down;
    logic [2:0]    dir_now;
    logic [11:0]   org_x, org_y, vol_anchor, stn_anchor, seen_x, seen_y, tap_x, tap_y;
    logic [31:0]   press_ms, tap_ms, poll_ms;
    logic          tap_waiting;

    tgr_pkg::out_word_t expected_gestures[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          sender_calm = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    logic [31:0] poll_clock = '0;

    function automatic logic [11:0] coord_dist(input logic [11:0] a, input logic [11:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic reset_predictor();
        gesture_cfg.screen_width         = tgr_pkg::RST_SCREEN_WIDTH;
        gesture_cfg.screen_height        = tgr_pkg::RST_SCREEN_HEIGHT;
        gesture_cfg.swipe_steps          = tgr_pkg::RST_SWIPE_STEPS;
        gesture_cfg.double_tap_window_ms = tgr_pkg::RST_DTAP_WINDOW;
        gesture_cfg.tap_move_limit       = tgr_pkg::RST_TAP_MOVE_LIMIT;
        gesture_cfg.long_press_ms        = tgr_pkg::RST_LONG_PRESS;
        gesture_cfg.poll_interval_ms     = tgr_pkg::RST_POLL_INTERVAL;
        gesture_cfg.swipe_start_distance = tgr_pkg::RST_SWIPE_START;
        was_down = 1'b1;
        dir_now = tgr_pkg::DIR_STAY;
        org_x = '0; org_y = '0; vol_anchor = '0; stn_anchor = '0;
        seen_x = '0; seen_y = '0; tap_x = '0; tap_y = '0;
        press_ms = '0; tap_ms = '0; poll_ms = '0;
        tap_waiting = 1'b0;
    endtask

    function automatic tgr_pkg::out_word_t predict_gesture(input tgr_pkg::in_word_t w);
        tgr_pkg::out_word_t r;
        logic [31:0] held;
        logic [11:0] ax, ay;
        int unsigned travel, w_div, h_div;
        logic        is_still, is_double;
        r = '0;
        w_div = (gesture_cfg.screen_width == 0) ? 1 : 32'(gesture_cfg.screen_width);
        h_div = (gesture_cfg.screen_height == 0) ? 1 : 32'(gesture_cfg.screen_height);

        if (!was_down && tap_waiting &&
            (w.now_ms - tap_ms) > 32'(gesture_cfg.double_tap_window_ms))
        begin
            tap_waiting = 1'b0;
            r.click = 1'b1;
        end

        if ((w.now_ms - poll_ms) > 32'(gesture_cfg.poll_interval_ms))
        begin
            poll_ms = w.now_ms;
            if (w.touched)
            begin
                seen_x = w.pos_x;
                seen_y = w.pos_y;
                if (!was_down)
                begin
                    org_x = w.pos_x; org_y = w.pos_y;
                    vol_anchor = w.pos_x; stn_anchor = w.pos_y;
                    dir_now = tgr_pkg::DIR_REQUEST;
                    press_ms = w.now_ms;
                end
                else
                begin
                    ax = coord_dist(w.pos_x, org_x);
                    ay = coord_dist(w.pos_y, org_y);
                    if (ax > gesture_cfg.swipe_start_distance ||
                        ay > gesture_cfg.swipe_start_distance)
                    begin
                        if (ax > ay)
                            dir_now = (w.pos_x > org_x) ? tgr_pkg::DIR_RIGHT : tgr_pkg::DIR_LEFT;
                        else
                            dir_now = (w.pos_y > org_y) ? tgr_pkg::DIR_DOWN : tgr_pkg::DIR_UP;
                    end
                    else
                        dir_now = tgr_pkg::DIR_REQUEST;

                    if (dir_now == tgr_pkg::DIR_LEFT || dir_now == tgr_pkg::DIR_RIGHT)
                    begin
                        press_ms = w.now_ms;
                        if (w.screen_mode == tgr_pkg::MODE_PLAYER ||
                            w.screen_mode == tgr_pkg::MODE_VOLUME)
                        begin
                            r.mode_request = tgr_pkg::REQ_VOLUME;
                            travel = 32'(coord_dist(vol_anchor, w.pos_x));
                            if (travel * 32'(gesture_cfg.swipe_steps) >= 2 * w_div)
                            begin
                                r.step = (w.pos_x < vol_anchor) ? tgr_pkg::STEP_POS
                                                                : tgr_pkg::STEP_NEG;
                                vol_anchor = w.pos_x;
                            end
                        end
                    end
                    else if (dir_now == tgr_pkg::DIR_UP || dir_now == tgr_pkg::DIR_DOWN)
                    begin
                        press_ms = w.now_ms;
                        if (w.screen_mode == tgr_pkg::MODE_PLAYER ||
                            w.screen_mode == tgr_pkg::MODE_STATIONS)
                        begin
                            r.mode_request = tgr_pkg::REQ_STATIONS;
                            travel = 32'(coord_dist(stn_anchor, w.pos_y));
                            if (travel * 32'(gesture_cfg.swipe_steps) >= 2 * h_div)
                            begin
                                r.step = (w.pos_y > stn_anchor) ? tgr_pkg::STEP_POS
                                                                : tgr_pkg::STEP_NEG;
                                stn_anchor = w.pos_y;
                            end
                        end
                    end
                end
            end
            else if (was_down)
            begin
                // only a release whose last touched poll stayed within the swipe start distance is judged
                if (dir_now == tgr_pkg::DIR_REQUEST)
                begin
                    held = w.now_ms - press_ms;
                    if (held < 32'(gesture_cfg.long_press_ms))
                    begin
                        is_still = coord_dist(seen_x, org_x) < gesture_cfg.tap_move_limit &&
                                   coord_dist(seen_y, org_y) < gesture_cfg.tap_move_limit;
                        if (held > tgr_pkg::TAP_MIN_MS && is_still)
                        begin
                            is_double = tap_waiting &&
                                (w.now_ms - tap_ms) <= 32'(gesture_cfg.double_tap_window_ms) &&
                                coord_dist(seen_x, tap_x) < gesture_cfg.tap_move_limit &&
                                coord_dist(seen_y, tap_y) < gesture_cfg.tap_move_limit;
                            if (is_double)
                            begin
                                tap_waiting = 1'b0;
                                r.double_tap = 1'b1;
                            end
                            else
                            begin
                                tap_waiting = 1'b1;
                                tap_ms = w.now_ms;
                                tap_x = seen_x;
                                tap_y = seen_y;
                            end
                        end
                        else
                            tap_waiting = 1'b0;
                    end
                    else
                    begin
                        tap_waiting = 1'b0;
                        r.mode_request = (w.screen_mode == tgr_pkg::MODE_PLAYER) ?
                                         tgr_pkg::REQ_STATIONS : tgr_pkg::REQ_PLAYER;
                    end
                end
                dir_now = tgr_pkg::DIR_STAY;
            end
            was_down = w.touched;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 100)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_results
        tgr_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_gestures.size() == 0)
                report_mismatch("word with nothing pending", int'(out_data), 0);
            else
            begin
                want = expected_gestures.pop_front();
                if (out_data.click !== want.click)
                    report_mismatch("click", int'(out_data.click), int'(want.click));
                if (out_data.double_tap !== want.double_tap)
                    report_mismatch("double_tap", int'(out_data.double_tap),
                                    int'(want.double_tap));
                if (out_data.mode_request !== want.mode_request)
                    report_mismatch("mode_request", int'(out_data.mode_request),
                                    int'(want.mode_request));
                if (out_data.step !== want.step)
                    report_mismatch("step", int'(out_data.step), int'(want.step));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("touch_gesture_recognizer regression: fail");
            $finish;
        end
    end

    // receiver: changing stall patterns, plus a long hold-off on request
    initial
    begin : receiver
        stall_pattern_t pattern;
        int unsigned    pattern_left;
        int unsigned    hold_left;
        pattern = STALL_NONE;
        pattern_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_OFF_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern = stall_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(10, 80);
                end
                pattern_left--;
                case (pattern)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_SPARSE:   out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_PERIODIC: out_stall <= (pattern_left % 3 == 0);
                    default:        out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    task automatic send_word(input tgr_pkg::in_word_t w);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = (sender_calm != 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_gestures.push_back(predict_gesture(w));
        words_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_gestures.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] want_rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            tgr_pkg::REG_SCREEN_WIDTH:
            begin
                gesture_cfg.screen_width = value[11:0];
                want_rd = 32'(value[11:0]);
            end
            tgr_pkg::REG_SCREEN_HEIGHT:
            begin
                gesture_cfg.screen_height = value[11:0];
                want_rd = 32'(value[11:0]);
            end
            tgr_pkg::REG_SWIPE_STEPS:
            begin
                gesture_cfg.swipe_steps = value[7:0];
                want_rd = 32'(value[7:0]);
            end
            tgr_pkg::REG_DTAP_WINDOW:
            begin
                gesture_cfg.double_tap_window_ms = value[15:0];
                want_rd = 32'(value[15:0]);
            end
            tgr_pkg::REG_TAP_MOVE_LIMIT:
            begin
                gesture_cfg.tap_move_limit = value[11:0];
                want_rd = 32'(value[11:0]);
            end
            tgr_pkg::REG_LONG_PRESS:
            begin
                gesture_cfg.long_press_ms = value[15:0];
                want_rd = 32'(value[15:0]);
            end
            tgr_pkg::REG_POLL_INTERVAL:
            begin
                gesture_cfg.poll_interval_ms = value[7:0];
                want_rd = 32'(value[7:0]);
            end
            tgr_pkg::REG_SWIPE_START:
            begin
                gesture_cfg.swipe_start_distance = value[11:0];
                want_rd = 32'(value[11:0]);
            end
            default: want_rd = '0;
        endcase
        // paddr still points at the register just written
        if (prdata !== want_rd)
            report_mismatch("register readback", int'(prdata), int'(want_rd));
    endtask

    task automatic apply_settings(input logic [31:0] width, input logic [31:0] height,
                                  input logic [31:0] steps, input logic [31:0] window,
                                  input logic [31:0] move_lim, input logic [31:0] long_ms,
                                  input logic [31:0] poll, input logic [31:0] swipe);
        cfg_write(tgr_pkg::REG_SCREEN_WIDTH, width);
        cfg_write(tgr_pkg::REG_SCREEN_HEIGHT, height);
        cfg_write(tgr_pkg::REG_SWIPE_STEPS, steps);
        cfg_write(tgr_pkg::REG_DTAP_WINDOW, window);
        cfg_write(tgr_pkg::REG_TAP_MOVE_LIMIT, move_lim);
        cfg_write(tgr_pkg::REG_LONG_PRESS, long_ms);
        cfg_write(tgr_pkg::REG_POLL_INTERVAL, poll);
        cfg_write(tgr_pkg::REG_SWIPE_START, swipe);
    endtask

    function automatic logic [11:0] coord_clamp(input int v);
        if (v < 0)
            return '0;
        if (v > COORD_MAX)
            return 12'(COORD_MAX);
        return v[11:0];
    endfunction

    function automatic int wobble(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int unsigned poll_gap();
        // now and then a poll too early to be processed
        if ($urandom_range(0, 11) == 0)
            return $urandom_range(0, 32'(gesture_cfg.poll_interval_ms));
        return 32'(gesture_cfg.poll_interval_ms) + 1 + $urandom_range(0, 25);
    endfunction

    function automatic int small_jitter();
        int j;
        j = int'(gesture_cfg.tap_move_limit) / 3;
        return (j > 8) ? 8 : j;
    endfunction

    function automatic int unsigned tap_hold();
        int unsigned top;
        top = (gesture_cfg.long_press_ms > 52) ? 32'(gesture_cfg.long_press_ms) - 1 : 60;
        if (top > 450)
            top = 450;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(45, 55);
        return $urandom_range(51, top);
    endfunction

    function automatic int unsigned pick_range(input int unsigned usual, input int unsigned full);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, full);
        return $urandom_range(0, usual);
    endfunction

    function automatic int unsigned pick_size();
        if ($urandom_range(0, 9) == 0)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 4095);
        return $urandom_range(100, 800);
    endfunction

    task automatic poll_at(input int unsigned gap, input logic touch, input int x, input int y,
                           input logic [1:0] mode);
        tgr_pkg::in_word_t w;
        poll_clock = poll_clock + gap;
        w.touched     = touch;
        w.pos_x       = coord_clamp(x);
        w.pos_y       = coord_clamp(y);
        w.now_ms      = poll_clock;
        w.screen_mode = mode;
        send_word(w);
    endtask

    task automatic press_and_release(input int x, input int y, input logic [1:0] mode,
                                     input int unsigned hold_ms, input int jitter);
        int unsigned elapsed, gp, rest;
        int          n;
        poll_at(poll_gap(), 1'b1, x, y, mode);
        elapsed = 0;
        n = $urandom_range(0, 3);
        gp = 32'(gesture_cfg.poll_interval_ms) + 1 + $urandom_range(0, 25);
        while (n > 0 && elapsed + gp < hold_ms)
        begin
            poll_at(gp, 1'b1, x + wobble(jitter), y + wobble(jitter), mode);
            elapsed += gp;
            n--;
            gp = 32'(gesture_cfg.poll_interval_ms) + 1 + $urandom_range(0, 25);
        end
        rest = hold_ms - elapsed;
        if (rest <= 32'(gesture_cfg.poll_interval_ms))
            rest = 32'(gesture_cfg.poll_interval_ms) + 1;
        poll_at(rest, 1'b0, int'($urandom_range(0, COORD_MAX)),
                int'($urandom_range(0, COORD_MAX)), mode);
    endtask

    task automatic tap_gesture();
        press_and_release(int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)),
                          2'($urandom_range(0, 3)), tap_hold(), small_jitter());
    endtask

    task automatic double_tap_gesture();
        int         x, y, j;
        logic [1:0] mode;
        x = int'($urandom_range(0, COORD_MAX));
        y = int'($urandom_range(0, COORD_MAX));
        j = small_jitter();
        mode = 2'($urandom_range(0, 3));
        press_and_release(x, y, mode, tap_hold(), j);
        press_and_release(x + wobble(j), y + wobble(j), mode, tap_hold(), j);
    endtask

    task automatic long_press_gesture();
        press_and_release(int'($urandom_range(0, COORD_MAX)), int'($urandom_range(0, COORD_MAX)),
                          2'($urandom_range(0, 3)),
                          32'(gesture_cfg.long_press_ms) + $urandom_range(0, 300),
                          small_jitter());
    endtask

    task automatic swipe_gesture();
        int         x, y, d, sgn, moves;
        bit         horiz;
        logic [1:0] mode;
        x = int'($urandom_range(0, COORD_MAX));
        y = int'($urandom_range(0, COORD_MAX));
        horiz = 1'($urandom_range(0, 1));
        sgn = $urandom_range(0, 1) ? 1 : -1;
        mode = 2'($urandom_range(0, 3));
        poll_at(poll_gap(), 1'b1, x, y, mode);
        moves = int'($urandom_range(1, 6));
        d = int'(gesture_cfg.swipe_start_distance) + int'($urandom_range(1, 12));
        repeat (moves)
        begin
            if (horiz)
            begin
                x = int'(coord_clamp(x + sgn * d));
                y = int'(coord_clamp(y + wobble(3)));
            end
            else
            begin
                y = int'(coord_clamp(y + sgn * d));
                x = int'(coord_clamp(x + wobble(3)));
            end
            poll_at(poll_gap(), 1'b1, x, y, mode);
            d = int'($urandom_range(1, 60));
            if ($urandom_range(0, 4) == 0)
                sgn = -sgn;
        end
        poll_at(poll_gap(), 1'b0, x, y, mode);
    endtask

    task automatic idle_polls();
        int unsigned gap;
        repeat ($urandom_range(1, 3))
        begin
            case ($urandom_range(0, 2))
                0:       gap = poll_gap();
                1:       gap = 32'(gesture_cfg.double_tap_window_ms) + 1 +
                               $urandom_range(0, 100);
                default: gap = $urandom_range(0, 32'(gesture_cfg.double_tap_window_ms));
            endcase
            poll_at(gap, 1'b0, int'($urandom_range(0, COORD_MAX)),
                    int'($urandom_range(0, COORD_MAX)), 2'($urandom_range(0, 3)));
        end
    endtask

    task automatic noise_word();
        tgr_pkg::in_word_t w;
        w.touched     = 1'($urandom_range(0, 1));
        w.pos_x       = 12'($urandom_range(0, COORD_MAX));
        w.pos_y       = 12'($urandom_range(0, COORD_MAX));
        w.now_ms      = $urandom();
        w.screen_mode = 2'($urandom_range(0, 3));
        send_word(w);
    endtask

    task automatic run_gesture_mix(input int n_words);
        int start, pick;
        start = words_sent;
        while (words_sent - start < n_words)
        begin
            pick = int'($urandom_range(0, 99));
            if (pick < 22)
                tap_gesture();
            else if (pick < 38)
                double_tap_gesture();
            else if (pick < 60)
                swipe_gesture();
            else if (pick < 70)
                long_press_gesture();
            else if (pick < 85)
                idle_polls();
            else
                noise_word();
        end
        wait_idle();
    endtask

    task automatic test_directed_gestures();
        // release straight out of reset has no direction and reports nothing
        poll_at(1000, 1'b0, 0, 0, tgr_pkg::MODE_PLAYER);
        // single tap held pending, then timed out into a click
        poll_at(30, 1'b1, 100, 100, tgr_pkg::MODE_PLAYER);
        poll_at(100, 1'b0, 100, 100, tgr_pkg::MODE_PLAYER);
        poll_at(350, 1'b0, 0, 0, tgr_pkg::MODE_PLAYER);
        // two taps close in time and place
        poll_at(30, 1'b1, 200, 200, tgr_pkg::MODE_PLAYER);
        poll_at(80, 1'b0, 200, 200, tgr_pkg::MODE_PLAYER);
        poll_at(40, 1'b1, 205, 203, tgr_pkg::MODE_PLAYER);
        poll_at(70, 1'b0, 0, 0, tgr_pkg::MODE_PLAYER);
        // press of exactly the minimum tap time across the time wrap
        poll_clock = 32'hFFFF_FFE0;
        poll_at(30, 1'b1, COORD_MAX, 0, MODE_OTHER);
        poll_at(50, 1'b0, COORD_MAX, 0, MODE_OTHER);
        // long presses from player and from volume
        poll_at(30, 1'b1, 50, 50, tgr_pkg::MODE_PLAYER);
        poll_at(1000, 1'b0, 50, 50, tgr_pkg::MODE_PLAYER);
        poll_at(30, 1'b1, 50, 50, tgr_pkg::MODE_VOLUME);
        poll_at(1200, 1'b0, 50, 50, tgr_pkg::MODE_VOLUME);
        // horizontal swipe in volume mode
        poll_at(30, 1'b1, 300, 100, tgr_pkg::MODE_VOLUME);
        poll_at(30, 1'b1, 250, 100, tgr_pkg::MODE_VOLUME);
        poll_at(30, 1'b0, 250, 100, tgr_pkg::MODE_VOLUME);
        // vertical swipe both ways, with an early poll that must be ignored
        poll_at(30, 1'b1, 100, 10, tgr_pkg::MODE_STATIONS);
        poll_at(30, 1'b1, 100, 60, tgr_pkg::MODE_STATIONS);
        poll_at(10, 1'b1, 3000, 3000, tgr_pkg::MODE_STATIONS);
        poll_at(30, 1'b1, 100, 40, tgr_pkg::MODE_STATIONS);
        poll_at(30, 1'b0, 100, 40, tgr_pkg::MODE_STATIONS);
        // corner to corner in a mode that ignores swipes
        poll_at(30, 1'b1, COORD_MAX, COORD_MAX, MODE_OTHER);
        poll_at(30, 1'b1, 0, 0, MODE_OTHER);
        poll_at(30, 1'b0, 0, 0, MODE_OTHER);
        wait_idle();
    endtask

    task automatic test_random_defaults();
        apply_settings(320, 240, 40, 300, 24, 1000, 20, 20);
        run_gesture_mix(220);
    endtask

    task automatic test_backpressure();
        sender_calm = 1;
        hold_requests++;
        run_gesture_mix(60);
        sender_calm = 0;
    endtask

    task automatic test_low_extremes();
        apply_settings(0, 1, 1, 0, 0, 0, 0, 0);
        run_gesture_mix(120);
    endtask

    task automatic test_high_extremes();
        apply_settings(4095, 4095, 255, 65535, 4095, 65535, 255, 4095);
        run_gesture_mix(120);
    endtask

    task automatic test_random_settings();
        repeat (3)
        begin
            apply_settings(pick_size(), pick_size(),
                           ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255),
                           pick_range(1000, 65535), pick_range(64, 4095),
                           pick_range(2000, 65535), pick_range(60, 255), pick_range(80, 4095));
            run_gesture_mix(130);
        end
    endtask

    initial
    begin
        reset_predictor();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_gestures();
        test_random_defaults();
        test_backpressure();
        test_low_extremes();
        test_high_extremes();
        test_random_settings();
        wait_idle();
        if (expected_gestures.size() != 0)
            report_mismatch("words never delivered", expected_gestures.size(), 0);
        if (mismatches == 0)
            $display("touch_gesture_recognizer regression: pass");
        else
            $display("touch_gesture_recognizer regression: fail");
        $finish;
    end

endmodule
